@@ src/dwp_pkg.sv @@
// Shared types, constants and command/status structs for the dual wiper
// pot angle tracker. No dependencies; every other file imports this package.
package dwp_pkg;

   localparam int ADC_FULL_SCALE_DEFAULT = 4095;

   localparam int WIPER_W    = 12;
   localparam int US_W       = 32;
   localparam int ANGLE_W    = 15;
   localparam int ABS_W      = 32;
   localparam int TURN_W     = 16;
   localparam int SPEED_W    = 32;
   localparam int ZONE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MAP_W      = 27;
   localparam int DIVN_W     = 34;
   localparam int DIVD_W     = 32;

   localparam int TURN      = 23040;
   localparam int HALF_TURN = 11520;
   localparam int SPAN      = 5760;
   localparam int HIGH_MARK = 19200;
   localparam int LOW_MARK  = 3840;
   localparam int MICRO     = 1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VALID_LOW,
      REG_VALID_HIGH,
      REG_BLEND_MARGIN,
      REG_CROSS_ONE,
      REG_CROSS_TWO,
      REG_HYSTERESIS,
      REG_SPEED_TOL
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_MAP1,
      DIV_MAP2,
      DIV_SPEED
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MAP1,
      ST_MAP1_WAIT,
      ST_MAP2,
      ST_MAP2_WAIT,
      ST_COMBINE,
      ST_REDUCE,
      ST_MOD,
      ST_TRACK,
      ST_SPEED,
      ST_SPEED_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      div_op_type div_op;
      logic       cap_map1;
      logic       cap_map2;
      logic       combine;
      logic       reduce_quick;
      logic       cap_mod;
      logic       track;
      logic       speed_quick;
      logic       cap_speed;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic zone_ok;
      logic need_map1;
      logic need_map2;
      logic need_mod;
      logic need_speed;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ src/dwp_req_if.sv @@
// Input channel interface: valid/ready plus one pair of wiper samples and
// elapsed time. Depends on dwp_pkg for field widths.
interface dwp_req_if import dwp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WIPER_W-1:0] wiper_a;
   logic [WIPER_W-1:0] wiper_b;
   logic [US_W-1:0]    elapsed_us;

   modport source (output valid, wiper_a, wiper_b, elapsed_us, input ready);
   modport sink (input valid, wiper_a, wiper_b, elapsed_us, output ready);
endinterface

@@ src/dwp_rsp_if.sv @@
// Result channel interface: valid/ready plus the decoded angle, tracking and
// velocity fields. Depends on dwp_pkg for field widths.
interface dwp_rsp_if import dwp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ANGLE_W-1:0]        circle_angle;
   logic signed [ABS_W-1:0]   absolute_angle;
   logic signed [ABS_W-1:0]   held_absolute;
   logic signed [TURN_W-1:0]  turn_count;
   logic signed [SPEED_W-1:0] speed;
   logic [ZONE_W-1:0]         zone;
   logic                      angle_valid;
   logic                      moved;

   modport source (output valid, circle_angle, absolute_angle, held_absolute, turn_count,
                   speed, zone, angle_valid, moved, input ready);
   modport sink (input valid, circle_angle, absolute_angle, held_absolute, turn_count,
                 speed, zone, angle_valid, moved, output ready);
endinterface

@@ src/dwp_csr_if.sv @@
// Configuration write channel interface: valid/ready, register index, data.
// Depends on dwp_pkg for widths.
interface dwp_csr_if import dwp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/dwp_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared by the map and
// velocity divides. Depends on dwp_pkg for operand widths.
module dwp_divider import dwp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic              done,
   output logic [DIVN_W-1:0] quot
);
   localparam int CNT_W = $clog2(DIVN_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dsr_ff, dsr_in;
   logic [DIVD_W:0]   trial;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVN_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVN_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DIVD_W'(trial - {1'b0, dsr_ff}) : trial[DIVD_W-1:0];
         quo_in = {quo_ff[DIVN_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

@@ src/dwp_datapath.sv @@
// Datapath: configuration registers, zone decode, linear maps, angle reduction,
// turn tracking, velocity and the result register. Uses dwp_pkg, dwp_divider.
module dwp_datapath import dwp_pkg::*; #(
   parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [WIPER_W-1:0]        in_wiper_a,
   input  logic [WIPER_W-1:0]        in_wiper_b,
   input  logic [US_W-1:0]           in_elapsed_us,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   input  logic                      out_ready,
   output logic                      out_valid,
   output logic [ANGLE_W-1:0]        out_circle_angle,
   output logic signed [ABS_W-1:0]   out_absolute_angle,
   output logic signed [ABS_W-1:0]   out_held_absolute,
   output logic signed [TURN_W-1:0]  out_turn_count,
   output logic signed [SPEED_W-1:0] out_speed,
   output logic [ZONE_W-1:0]         out_zone,
   output logic                      out_angle_valid,
   output logic                      out_moved
);
   // one turn is 45 * 2^9; the odd factor is taken out by a reciprocal multiply
   localparam int LOW_BITS    = 9;
   localparam int TURN_ODD    = 45;
   localparam int RECIP       = 186414;
   localparam int RECIP_SHIFT = 23;
   localparam int HI_W        = MAP_W - LOW_BITS;
   localparam int PROD_W      = HI_W + 18;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;

   // configuration
   logic [11:0] vl_ff, vh_ff;
   logic [9:0]  mg_ff;
   logic [14:0] c1_ff, c2_ff;
   logic [13:0] hyst_ff;
   logic [15:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff   <= 12'd410;
         vh_ff   <= 12'd3685;
         mg_ff   <= 10'd205;
         c1_ff   <= 15'd8640;
         c2_ff   <= 15'd14400;
         hyst_ff <= 14'd32;
         tol_ff  <= 16'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_VALID_LOW:    vl_ff   <= csr_data[11:0];
            REG_VALID_HIGH:   vh_ff   <= csr_data[11:0];
            REG_BLEND_MARGIN: mg_ff   <= csr_data[9:0];
            REG_CROSS_ONE:    c1_ff   <= csr_data[14:0];
            REG_CROSS_TWO:    c2_ff   <= csr_data[14:0];
            REG_HYSTERESIS:   hyst_ff <= csr_data[13:0];
            REG_SPEED_TOL:    tol_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // input item, wipers clamped to full scale
   logic [WIPER_W-1:0] a_ff, b_ff, a_clamp, b_clamp;
   logic [US_W-1:0]    us_ff;

   assign a_clamp = (32'(in_wiper_a) > ADC_FULL_SCALE) ? WIPER_W'(ADC_FULL_SCALE) : in_wiper_a;
   assign b_clamp = (32'(in_wiper_b) > ADC_FULL_SCALE) ? WIPER_W'(ADC_FULL_SCALE) : in_wiper_b;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff  <= a_clamp;
         b_ff  <= b_clamp;
         us_ff <= in_elapsed_us;
      end
   end

   // zone decode
   logic signed [13:0] lo_lim;
   logic [13:0]        hi_lim;
   logic               ua, ub, alo, ahi, blo, bhi, b_gt_a, zone_ok;
   logic [ZONE_W-1:0]  zone;

   always_comb begin
      lo_lim = $signed({2'b00, vl_ff}) - $signed({4'b0000, mg_ff});
      hi_lim = {2'b00, vh_ff} + {4'b0000, mg_ff};
      ua     = ($signed({2'b00, a_ff}) >= lo_lim) && ({2'b00, a_ff} <= hi_lim);
      ub     = ($signed({2'b00, b_ff}) >= lo_lim) && ({2'b00, b_ff} <= hi_lim);
      alo    = 32'({a_ff, 1'b0}) < ADC_FULL_SCALE;
      ahi    = 32'({a_ff, 1'b0}) > ADC_FULL_SCALE;
      blo    = 32'({b_ff, 1'b0}) < ADC_FULL_SCALE;
      bhi    = 32'({b_ff, 1'b0}) > ADC_FULL_SCALE;
      b_gt_a = b_ff > a_ff;
      zone_ok = 1'b1;
      zone    = 3'd0;
      if (ua == ub) begin
         if (alo && blo) zone = 3'd1;
         else if (alo && bhi) zone = 3'd3;
         else if (ahi && bhi) zone = 3'd5;
         else if (ahi && blo) zone = 3'd7;
         else if (ub) zone = b_gt_a ? 3'd2 : 3'd6;
         else zone_ok = 1'b0;
      end else if (ub) begin
         zone = b_gt_a ? 3'd2 : 3'd6;
      end else begin
         zone = b_gt_a ? 3'd4 : 3'd0;
      end
   end

   // divider operand selection
   div_op_type           op_ff, op_sel;
   logic                 is_map1, asc;
   logic [WIPER_W-1:0]   x_sel, from_sel, to_sel;
   logic signed [12:0]   diff, dd;
   logic [11:0]          absdiff, den;
   logic                 map_neg;
   logic [24:0]          map_mag;
   logic signed [16:0]   y0;
   logic signed [MAP_W-1:0] ang_raw_ff, map1_ff, map2_ff;
   logic signed [ANGLE_W-1:0] d_ff;
   logic [13:0]          dabs;
   logic [DIVN_W-1:0]    div_n;
   logic [DIVD_W-1:0]    div_d;
   logic [MAP_W-1:0]     raw_abs;
   logic                 div_done;
   logic [DIVN_W-1:0]    div_q;

   always_comb begin
      op_sel   = cmd.div_start ? cmd.div_op : op_ff;
      is_map1  = op_sel == DIV_MAP1;
      asc      = is_map1 ? (zone == 3'd3 || zone == 3'd4 || zone == 3'd5)
                         : (zone == 3'd1 || zone == 3'd2 || zone == 3'd3);
      x_sel    = is_map1 ? a_ff : b_ff;
      from_sel = asc ? vl_ff : vh_ff;
      to_sel   = asc ? vh_ff : vl_ff;
      diff     = $signed({1'b0, x_sel}) - $signed({1'b0, from_sel});
      dd       = $signed({1'b0, to_sel}) - $signed({1'b0, from_sel});
      map_neg  = diff[12] ^ dd[12];
      absdiff  = diff[12] ? 12'(-diff) : diff[11:0];
      den      = dd[12] ? 12'(-dd) : dd[11:0];
      map_mag  = 25'(absdiff) * 25'(SPAN);
      if (is_map1) y0 = asc ? 17'($signed({2'b00, c2_ff}) - 17'sd5760)
                            : 17'($signed({2'b00, c1_ff}) - 17'sd5760);
      else y0 = asc ? $signed({2'b00, c1_ff}) : $signed({2'b00, c2_ff});
      dabs    = d_ff[ANGLE_W-1] ? 14'(-d_ff) : d_ff[13:0];
      raw_abs = ang_raw_ff[MAP_W-1] ? MAP_W'(-ang_raw_ff) : ang_raw_ff;
      case (op_sel)
         DIV_SPEED: begin
            div_n = DIVN_W'(DIVN_W'(dabs) * DIVN_W'(MICRO)) + DIVN_W'(us_ff >> 1);
            div_d = us_ff;
         end
         default: begin
            div_n = DIVN_W'(map_mag) + DIVN_W'(den >> 1);
            div_d = DIVD_W'(den);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) op_ff <= cmd.div_op;
   end

   dwp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quot     (div_q)
   );

   // map result
   logic signed [MAP_W-1:0] lin_val, lin_fold, blend_sum, blend_val;

   always_comb begin
      if (den == 12'd0) lin_val = MAP_W'(y0);
      else lin_val = (map_neg ? -MAP_W'(div_q[24:0]) : MAP_W'(div_q[24:0])) + MAP_W'(y0);
      lin_fold = (!asc && lin_val > MAP_W'(TURN)) ? lin_val - MAP_W'(TURN) : lin_val;
      blend_sum = map1_ff + map2_ff;
      if (!blend_sum[MAP_W-1]) blend_val = (blend_sum + MAP_W'(1)) >>> 1;
      else blend_val = -MAP_W'((-blend_sum + MAP_W'(1)) >>> 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_map1) map1_ff <= lin_val;
      if (cmd.cap_map2) map2_ff <= lin_fold;
      if (cmd.combine) begin
         if (zone == 3'd0 || zone == 3'd4) ang_raw_ff <= map1_ff;
         else if (zone == 3'd2 || zone == 3'd6) ang_raw_ff <= map2_ff;
         else ang_raw_ff <= blend_val;
      end
   end

   // reduce into one turn
   logic               in0, neg1, up1;
   logic [ANGLE_W-1:0] ang_ff, quick_ang, mod_ang, rem15;
   logic [HI_W-1:0]    raw_hi, hi_rem;
   logic [PROD_W-1:0]  recip_prod;
   logic [QUO_W-1:0]   turn_q_ff, turn_q_in;

   always_comb begin
      in0  = ang_raw_ff >= 0 && ang_raw_ff < MAP_W'(TURN);
      neg1 = ang_raw_ff < 0 && ang_raw_ff > MAP_W'(-TURN);
      up1  = ang_raw_ff >= MAP_W'(TURN) && ang_raw_ff < MAP_W'(2 * TURN);
      if (in0) quick_ang = ANGLE_W'(ang_raw_ff);
      else if (neg1) quick_ang = ANGLE_W'(ang_raw_ff + MAP_W'(TURN));
      else quick_ang = ANGLE_W'(ang_raw_ff - MAP_W'(TURN));
      // quotient by 45 of the magnitude above the low bits, registered
      raw_hi     = raw_abs[MAP_W-1:LOW_BITS];
      recip_prod = PROD_W'(raw_hi) * PROD_W'(RECIP);
      turn_q_in  = recip_prod[PROD_W-1:RECIP_SHIFT];
      hi_rem     = raw_hi - HI_W'(HI_W'(turn_q_ff) * HI_W'(TURN_ODD));
      rem15      = {hi_rem[5:0], raw_abs[LOW_BITS-1:0]};
      mod_ang = (ang_raw_ff[MAP_W-1] && rem15 != '0) ? ANGLE_W'(TURN) - rem15 : rem15;
   end

   always_ff @(posedge clock) begin
      turn_q_ff <= turn_q_in;
      if (cmd.reduce_quick) ang_ff <= quick_ang;
      else if (cmd.cap_mod) ang_ff <= mod_ang;
   end

   // tracking state
   logic [ANGLE_W-1:0]       held_angle_ff;
   logic signed [TURN_W-1:0] turns_ff, turns_new;
   logic signed [ABS_W-1:0]  held_abs_ff, absa_ff, absa_new;
   logic signed [15:0]       dw;
   logic signed [ANGLE_W-1:0] d_new;
   logic [13:0]              dnew_abs;
   logic                     moved_ff;

   always_comb begin
      dw = $signed({1'b0, ang_ff}) - $signed({1'b0, held_angle_ff});
      if (dw > 16'sd11520) dw = dw - 16'sd23040;
      else if (dw < -16'sd11520) dw = dw + 16'sd23040;
      d_new    = ANGLE_W'(dw);
      dnew_abs = d_new[ANGLE_W-1] ? 14'(-d_new) : d_new[13:0];
      turns_new = turns_ff;
      if (held_angle_ff > ANGLE_W'(HIGH_MARK) && ang_ff < ANGLE_W'(LOW_MARK)) begin
         if (turns_ff != 16'sh7FFF) turns_new = turns_ff + 16'sd1;
      end else if (held_angle_ff < ANGLE_W'(LOW_MARK) && ang_ff > ANGLE_W'(HIGH_MARK)) begin
         if (turns_ff != -16'sh8000) turns_new = turns_ff - 16'sd1;
      end
      absa_new = ABS_W'(ABS_W'(turns_new) * ABS_W'(TURN)) + $signed({17'd0, ang_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_angle_ff <= '0;
         turns_ff      <= '0;
         held_abs_ff   <= '0;
      end else if (cmd.track) begin
         turns_ff <= turns_new;
         if (dnew_abs > hyst_ff) begin
            held_angle_ff <= ang_ff;
            held_abs_ff   <= absa_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.track) begin
         d_ff     <= d_new;
         absa_ff  <= absa_new;
         moved_ff <= dnew_abs > hyst_ff;
      end
   end

   // velocity
   logic signed [SPEED_W-1:0] speed_ff, quick_speed, div_speed;
   logic [SPEED_W-1:0]        smag;

   always_comb begin
      if (d_ff == '0) quick_speed = '0;
      else if (!d_ff[ANGLE_W-1]) quick_speed = 32'sh7FFF_FFFF;
      else quick_speed = 32'sh8000_0000;
      if (d_ff[ANGLE_W-1])
         smag = (div_q > DIVN_W'(34'h0_8000_0000)) ? 32'h8000_0000 : div_q[31:0];
      else
         smag = (div_q > DIVN_W'(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
      if (smag <= SPEED_W'(tol_ff)) div_speed = '0;
      else div_speed = d_ff[ANGLE_W-1] ? -$signed(smag) : $signed(smag);
   end

   always_ff @(posedge clock) begin
      if (cmd.speed_quick) speed_ff <= quick_speed;
      else if (cmd.cap_speed) speed_ff <= div_speed;
   end

   // result register
   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.finish) out_valid_ff <= 1'b1;
      else if (out_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_held_absolute <= held_abs_ff;
         out_turn_count    <= turns_ff;
         if (zone_ok) begin
            out_circle_angle   <= ang_ff;
            out_absolute_angle <= absa_ff;
            out_speed          <= speed_ff;
            out_zone           <= zone;
            out_angle_valid    <= 1'b1;
            out_moved          <= moved_ff;
         end else begin
            out_circle_angle   <= held_angle_ff;
            out_absolute_angle <= ABS_W'(ABS_W'(turns_ff) * ABS_W'(TURN))
                                  + $signed({17'd0, held_angle_ff});
            out_speed          <= '0;
            out_zone           <= '0;
            out_angle_valid    <= 1'b0;
            out_moved          <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;

   always_comb begin
      status.zone_ok    = zone_ok;
      status.need_map1  = zone == 3'd0 || zone == 3'd4 || zone[0];
      status.need_map2  = zone == 3'd2 || zone == 3'd6 || zone[0];
      status.need_mod   = !(in0 || neg1 || up1);
      status.need_speed = us_ff != '0 && d_ff != '0;
      status.div_done   = div_done;
      status.out_free   = !out_valid_ff || out_ready;
   end
endmodule

@@ src/dwp_ctrl.sv @@
// Controller state machine: sequences decode, divides, tracking and result
// write for one item. Uses dwp_pkg for state, command and status types.
module dwp_ctrl import dwp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_op = DIV_MAP1;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.zone_ok) state_in = ST_FINISH;
            else if (status.need_map1) state_in = ST_MAP1;
            else state_in = ST_MAP2;
         end
         ST_MAP1: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MAP1;
            state_in      = ST_MAP1_WAIT;
         end
         ST_MAP1_WAIT: begin
            if (status.div_done) begin
               cmd.cap_map1 = 1'b1;
               state_in     = status.need_map2 ? ST_MAP2 : ST_COMBINE;
            end
         end
         ST_MAP2: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_MAP2;
            state_in      = ST_MAP2_WAIT;
         end
         ST_MAP2_WAIT: begin
            if (status.div_done) begin
               cmd.cap_map2 = 1'b1;
               state_in     = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_REDUCE;
         end
         ST_REDUCE: begin
            // a far-out raw angle goes through ST_MOD for the modulo
            if (status.need_mod) begin
               state_in = ST_MOD;
            end else begin
               cmd.reduce_quick = 1'b1;
               state_in         = ST_TRACK;
            end
         end
         ST_MOD: begin
            cmd.cap_mod = 1'b1;
            state_in    = ST_TRACK;
         end
         ST_TRACK: begin
            cmd.track = 1'b1;
            state_in  = ST_SPEED;
         end
         ST_SPEED: begin
            if (status.need_speed) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_SPEED;
               state_in      = ST_SPEED_WAIT;
            end else begin
               cmd.speed_quick = 1'b1;
               state_in        = ST_FINISH;
            end
         end
         ST_SPEED_WAIT: begin
            if (status.div_done) begin
               cmd.cap_speed = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register can take this transaction
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

@@ src/dual_wiper_pot_angle_tracker_unit.sv @@
// Top level of the dual wiper pot angle tracker: channels, controller and
// datapath. Depends on dwp_pkg, the three channel interfaces, dwp_ctrl, dwp_datapath.
//
// One item is worked at a time, and each gives one result. An item makes
// one map divide through the single radix-2 divider (one quotient bit per cycle
// over 34 bits) with one wiper trusted and two in a blend zone, and passes
// through ST_MOD when the raw angle needs a full modulo reduction (done by a
// reciprocal multiply, not the divider); an undecodable sample goes straight
// to its result. Velocity skips its divide when the change or elapsed time is
// zero. A result that waits on the sink stalls the item behind it in its last
// state. The result register lets the next item be accepted while a result
// waits. Configuration writes are always accepted.
module dual_wiper_pot_angle_tracker_unit import dwp_pkg::*; #(
   parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   dwp_req_if.sink  req,
   dwp_rsp_if.source rsp,
   dwp_csr_if.sink  csr
);
   cmd_type    cmd;
   status_type status;
   logic       in_ready;

   assign req.ready = in_ready;
   assign csr.ready = 1'b1;

   dwp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   dwp_datapath #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .in_wiper_a         (req.wiper_a),
      .in_wiper_b         (req.wiper_b),
      .in_elapsed_us      (req.elapsed_us),
      .csr_write          (csr.valid),
      .csr_index          (csr.index),
      .csr_data           (csr.data),
      .out_ready          (rsp.ready),
      .out_valid          (rsp.valid),
      .out_circle_angle   (rsp.circle_angle),
      .out_absolute_angle (rsp.absolute_angle),
      .out_held_absolute  (rsp.held_absolute),
      .out_turn_count     (rsp.turn_count),
      .out_speed          (rsp.speed),
      .out_zone           (rsp.zone),
      .out_angle_valid    (rsp.angle_valid),
      .out_moved          (rsp.moved)
   );

`ifndef ASSERT_OFF
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result written while previous transaction still pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("input accepted while an item is in progress");

   a_invalid_result: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.angle_valid) |-> (rsp.speed == 0 && !rsp.moved && rsp.zone == 0))
      else $error("invalid zone result carries motion");

   a_single_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start)
      else $error("divider restarted back to back");
`endif
endmodule
